// ===== hw/rtl/server_info_reply_parser_top_assert.svh =====
// assertion macros for the server-info reply parser
// used by server_info_reply_parser_top, no other dependencies
`ifndef SERVER_INFO_REPLY_PARSER_TOP_ASSERT_SVH
`define SERVER_INFO_REPLY_PARSER_TOP_ASSERT_SVH

// generic clocked check with async active-low reset disable
`define SIRP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sirp: assertion failed");

// shorthand on the block's own clock and reset
`define SIRP_CHECK(label, prop) `SIRP_ASSERT(label, clk_i, rst_ni, prop)

`endif

// ===== hw/rtl/sirp_pkg.sv =====
// types and constants for the server-info reply parser
// no dependencies
package sirp_pkg;

  localparam int unsigned ResQDepth = 4;
  localparam int unsigned ResQPtrW  = $clog2(ResQDepth);
  localparam int unsigned ResQCntW  = $clog2(ResQDepth + 1);
  localparam int unsigned MaxRes    = 3;

  localparam logic [7:0] HdrByte     = 8'hFF;
  localparam logic [7:0] TypeChal    = 8'h41;
  localparam logic [7:0] TypeNewer   = 8'h49;
  localparam logic [7:0] TypeOlder   = 8'h6d;
  localparam logic [2:0] BodyPos     = 3'd5;
  localparam logic [2:0] TypePos     = 3'd4;

  localparam logic KindField  = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef enum logic [3:0] {
    FID_NAME     = 4'd0,
    FID_MAP      = 4'd1,
    FID_DIR      = 4'd2,
    FID_DESC     = 4'd3,
    FID_VERSION  = 4'd4,
    FID_APPID    = 4'd5,
    FID_PLAYERS  = 4'd6,
    FID_MAXPLAY  = 4'd7,
    FID_BOTS     = 4'd8,
    FID_TYPE     = 4'd9,
    FID_OS       = 4'd10,
    FID_PASSWORD = 4'd11,
    FID_SECURE   = 4'd12
  } field_id_e;

  typedef enum logic [2:0] {
    ST_OK_NEWER  = 3'd0,
    ST_OK_OLDER  = 3'd1,
    ST_SHORT     = 3'd2,
    ST_BAD_HDR   = 3'd3,
    ST_CHALLENGE = 3'd4,
    ST_UNKNOWN   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    LAYOUT_NONE  = 2'd0,
    LAYOUT_NEWER = 2'd1,
    LAYOUT_OLDER = 2'd2
  } layout_e;

  // step numbers of the newer layout used by the parser
  localparam logic [4:0] NwStepProto   = 5'd0;
  localparam logic [4:0] NwStepStrLast = 5'd4;
  localparam logic [4:0] NwStepAppLo   = 5'd5;
  localparam logic [4:0] NwStepAppHi   = 5'd6;
  localparam logic [4:0] NwStepByteLst = 5'd11;
  localparam logic [4:0] NwStepPass    = 5'd12;
  localparam logic [4:0] NwStepSecure  = 5'd13;
  localparam logic [4:0] NwStepVersion = 5'd14;

  // steps of the older layout
  localparam logic [4:0] OdStepAddr    = 5'd0;
  localparam logic [4:0] OdStepStrLast = 5'd4;
  localparam logic [4:0] OdStepPlayers = 5'd5;
  localparam logic [4:0] OdStepMaxPl   = 5'd6;
  localparam logic [4:0] OdStepType    = 5'd8;
  localparam logic [4:0] OdStepPass    = 5'd10;
  localparam logic [4:0] OdStepSecure  = 5'd11;

  typedef struct packed {
    logic       kind;
    logic [3:0] field_id;
    logic [15:0] field_value;
    logic [2:0] status;
    logic       last_of_run;
  } result_t;

  function automatic result_t make_field(logic [3:0] id, logic [15:0] value);
    result_t r;
    r.kind        = KindField;
    r.field_id    = id;
    r.field_value = value;
    r.status      = ST_OK_NEWER;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic result_t make_status(status_e st);
    result_t r;
    r.kind        = KindStatus;
    r.field_id    = FID_NAME;
    r.field_value = 16'd0;
    r.status      = st;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

// ===== hw/rtl/sirp_in_if.sv =====
// input byte channel of the server-info reply parser
// no dependencies
interface sirp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

// ===== hw/rtl/sirp_out_if.sv =====
// result channel of the server-info reply parser
// no dependencies
interface sirp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  field_id;
  logic [15:0] field_value;
  logic [2:0]  status;
  logic        last_of_run;

  modport source (output valid, output kind, output field_id, output field_value,
                  output status, output last_of_run, input ready);
  modport sink   (input valid, input kind, input field_id, input field_value,
                  input status, input last_of_run, output ready);
endinterface

// ===== hw/rtl/server_info_reply_parser_top.sv =====
// datapath: a byte is registered in the input slot on acceptance, its results enter a 4-entry
// result queue once there is room for them, and the queue head is offered straight from the queue
// throughput: one byte per cycle with the output ready; the queue absorbs two extra beats,
// and each further beat beyond one per byte holds the input back
// reset: asynchronous, clears parse state, input slot and result queue; no clearing pass
// depends on sirp_pkg, sirp_in_if, sirp_out_if, server_info_reply_parser_top_assert.svh
`include "server_info_reply_parser_top_assert.svh"

module server_info_reply_parser_top
  import sirp_pkg::*;
#(
  parameter int unsigned STRING_BUFFER = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sirp_in_if.sink     in_i,
  sirp_out_if.source  out_o
);

  localparam logic [6:0] StrLastIdx = 7'(STRING_BUFFER - 1);

  // input slot
  logic       slot_vld_q;
  logic [7:0] slot_byte_q;
  logic       slot_last_q;

  // parse state
  logic [2:0] byte_pos_q, byte_pos_d;
  layout_e    layout_q, layout_d;
  status_e    reject_q, reject_d;
  logic [4:0] step_q, step_d;
  logic [6:0] chars_q, chars_d;
  logic [7:0] held_q, held_d;

  // result queue
  result_t              resq_q [ResQDepth];
  logic [ResQPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [ResQCntW-1:0]  cnt_q, cnt_d;

  result_t    res [MaxRes];
  logic [1:0] res_n;
  logic       proc;
  logic       pop;
  logic [ResQCntW:0] free_slots;

  logic       in_acc;
  logic       str_sel;
  logic       str_show;
  logic [3:0] str_id;
  logic [7:0] b;

  assign b          = slot_byte_q;
  assign pop        = out_o.valid && out_o.ready;
  assign free_slots = (ResQCntW+1)'(ResQDepth) - {1'b0, cnt_q} + (ResQCntW+1)'(pop);
  assign proc       = slot_vld_q && (free_slots >= (ResQCntW+1)'(MaxRes));
  assign in_i.ready = !slot_vld_q || proc;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= 1'b0;
    end else if (in_acc) begin
      slot_vld_q <= 1'b1;
    end else if (proc) begin
      slot_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      slot_byte_q <= in_i.data_byte;
      slot_last_q <= in_i.end_of_packet;
    end
  end

  // string field selection; string ids follow the step order (step - 1)
  always_comb begin
    str_sel  = 1'b0;
    str_show = 1'b0;
    str_id   = FID_NAME;
    if (layout_q == LAYOUT_NEWER) begin
      if (step_q != NwStepProto && step_q <= NwStepStrLast) begin
        str_sel  = 1'b1;
        str_show = 1'b1;
        str_id   = 4'(step_q - 5'd1);
      end else if (step_q == NwStepVersion) begin
        str_sel  = 1'b1;
        str_show = 1'b1;
        str_id   = FID_VERSION;
      end
    end else if (layout_q == LAYOUT_OLDER) begin
      if (step_q == OdStepAddr) begin
        str_sel = 1'b1;
      end else if (step_q <= OdStepStrLast) begin
        str_sel  = 1'b1;
        str_show = 1'b1;
        str_id   = 4'(step_q - 5'd1);
      end
    end
  end

  always_comb begin
    byte_pos_d = byte_pos_q;
    layout_d   = layout_q;
    reject_d   = reject_q;
    step_d     = step_q;
    chars_d    = chars_q;
    held_d     = held_q;
    res_n      = 2'd0;
    for (int i = 0; i < MaxRes; i++) begin
      res[i] = make_status(ST_OK_NEWER);
    end

    if (byte_pos_q < TypePos) begin
      if (b != HdrByte && reject_q == ST_OK_NEWER) begin
        reject_d = ST_BAD_HDR;
      end
      byte_pos_d = byte_pos_q + 3'd1;
    end else if (byte_pos_q == TypePos) begin
      if (reject_q == ST_OK_NEWER) begin
        priority case (b)
          TypeNewer: layout_d = LAYOUT_NEWER;
          TypeOlder: layout_d = LAYOUT_OLDER;
          TypeChal:  reject_d = ST_CHALLENGE;
          default:   reject_d = ST_UNKNOWN;
        endcase
      end
      byte_pos_d = BodyPos;
    end else if (reject_q == ST_OK_NEWER) begin
      if (str_sel) begin
        // a string ends at a zero byte or its last buffer slot, which is dropped
        if (chars_q >= StrLastIdx || b == 8'd0) begin
          chars_d = 7'd0;
          step_d  = step_q + 5'd1;
        end else begin
          if (str_show) begin
            res[0] = make_field(str_id, {8'd0, b});
            res_n  = 2'd1;
          end
          chars_d = chars_q + 7'd1;
        end
      end else if (layout_q == LAYOUT_NEWER) begin
        if (step_q == NwStepProto) begin
          step_d = step_q + 5'd1;
        end else if (step_q == NwStepAppLo) begin
          // a lone appid byte at packet end counts as players
          if (slot_last_q) begin
            res[0] = make_field(FID_PLAYERS, {8'd0, b});
            res_n  = 2'd1;
          end else begin
            held_d = b;
          end
          step_d = NwStepAppHi;
        end else if (step_q == NwStepAppHi) begin
          res[0] = make_field(FID_APPID, {b, held_q});
          res_n  = 2'd1;
          step_d = step_q + 5'd1;
        end else if (step_q <= NwStepByteLst) begin
          res[0] = make_field(4'(step_q - 5'd1), {8'd0, b});
          res_n  = 2'd1;
          step_d = step_q + 5'd1;
        end else if (step_q == NwStepPass) begin
          // a lone password byte at packet end is read as a version char
          if (slot_last_q) begin
            if (b != 8'd0) begin
              res[0] = make_field(FID_VERSION, {8'd0, b});
              res_n  = 2'd1;
            end
          end else begin
            held_d = b;
          end
          step_d = NwStepSecure;
        end else if (step_q == NwStepSecure) begin
          res[0] = make_field(FID_PASSWORD, {8'd0, held_q});
          res[1] = make_field(FID_SECURE, {8'd0, b});
          res_n  = 2'd2;
          step_d = NwStepVersion;
        end
      end else if (layout_q == LAYOUT_OLDER) begin
        if (step_q <= OdStepSecure) begin
          step_d = step_q + 5'd1;
          res_n  = 2'd1;
          if (step_q == OdStepPlayers) begin
            res[0] = make_field(FID_PLAYERS, {8'd0, b});
          end else if (step_q == OdStepMaxPl) begin
            res[0] = make_field(FID_MAXPLAY, {8'd0, b});
          end else if (step_q == OdStepType) begin
            res[0] = make_field(FID_TYPE, {8'd0, b});
          end else if (step_q == OdStepPass) begin
            res[0] = make_field(FID_PASSWORD, {8'd0, b});
          end else if (step_q == OdStepSecure) begin
            res[0] = make_field(FID_SECURE, {8'd0, b});
          end else begin
            // protocol and environment bytes are skipped
            res_n = 2'd0;
          end
        end
      end
    end

    if (slot_last_q) begin
      if (byte_pos_q < BodyPos) begin
        res[res_n] = make_status(ST_SHORT);
      end else if (reject_q != ST_OK_NEWER) begin
        res[res_n] = make_status(reject_q);
      end else if (layout_q == LAYOUT_OLDER) begin
        res[res_n] = make_status(ST_OK_OLDER);
      end else begin
        res[res_n] = make_status(ST_OK_NEWER);
      end
      res_n      = res_n + 2'd1;
      byte_pos_d = 3'd0;
      layout_d   = LAYOUT_NONE;
      reject_d   = ST_OK_NEWER;
      step_d     = 5'd0;
      chars_d    = 7'd0;
      held_d     = 8'd0;
    end

    if (res_n != 2'd0) begin
      res[res_n - 2'd1].last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q <= 3'd0;
      layout_q   <= LAYOUT_NONE;
      reject_q   <= ST_OK_NEWER;
      step_q     <= 5'd0;
      chars_q    <= 7'd0;
      held_q     <= 8'd0;
    end else if (proc) begin
      byte_pos_q <= byte_pos_d;
      layout_q   <= layout_d;
      reject_q   <= reject_d;
      step_q     <= step_d;
      chars_q    <= chars_d;
      held_q     <= held_d;
    end
  end

  // result queue
  always_comb begin
    cnt_d = cnt_q - ResQCntW'(pop);
    if (proc) begin
      cnt_d = cnt_d + ResQCntW'(res_n);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (proc) begin
        wr_ptr_q <= wr_ptr_q + ResQPtrW'(res_n);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + ResQPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      for (int i = 0; i < MaxRes; i++) begin
        if (2'(i) < res_n) begin
          resq_q[wr_ptr_q + ResQPtrW'(i)] <= res[i];
        end
      end
    end
  end

  assign out_o.valid       = (cnt_q != '0);
  assign out_o.kind        = resq_q[rd_ptr_q].kind;
  assign out_o.field_id    = resq_q[rd_ptr_q].field_id;
  assign out_o.field_value = resq_q[rd_ptr_q].field_value;
  assign out_o.status      = resq_q[rd_ptr_q].status;
  assign out_o.last_of_run = resq_q[rd_ptr_q].last_of_run;

  `SIRP_CHECK(a_resq_bound, cnt_q <= ResQCntW'(ResQDepth))
  `SIRP_CHECK(a_last_gives_status, proc && slot_last_q |-> res_n != 2'd0)
  `SIRP_CHECK(a_last_resets_state,
      proc && slot_last_q |=> byte_pos_q == 3'd0 && step_q == 5'd0 && chars_q == 7'd0)
  `SIRP_CHECK(a_header_no_fields,
      proc && byte_pos_q < BodyPos |-> res_n == 2'(slot_last_q))

endmodule
